FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`endif

FILE: hw/rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 12;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 8'd1;
    localparam logic [31:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_SIZE  = 3'd1,
        STATUS_NO_MEMORY = 3'd2,
        STATUS_NULL_FREE = 3'd3,
        STATUS_UNKNOWN   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_RESP
    } ffba_state_t;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] request_size;
        logic [31:0]        block_address;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_address;
    } out_item_t;

    // One table entry as stored in the block RAM.
    typedef struct packed {
        logic [31:0] base;
        logic [30:0] size;
        logic        free;
    } entry_t;

    typedef struct packed {
        logic        base_wr;
        logic [31:0] base_val;
        logic [31:0] limit;
    } cfg_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_t;

endpackage

FILE: hw/rtl/ffba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/ffba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: walks the block table newest first through the RAM,
// marks entries, appends new blocks and tracks heap top and block count.
// ----------------------------------------------------------------------------
module ffba_ctrl #(
    parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
    localparam int IDX_W       = $clog2(MAX_BLOCKS),
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ffba_pkg::in_item_t in_item,
    input  ffba_pkg::cfg_t     cfg,
    output ffba_pkg::res_t     res,
    input  logic               res_ready,
    output logic               ram_wr_en,
    output logic [IDX_W-1:0]   ram_wr_addr,
    output ffba_pkg::entry_t   ram_wr_data,
    output logic               ram_rd_en,
    output logic [IDX_W-1:0]   ram_rd_addr,
    input  ffba_pkg::entry_t   ram_rd_data
);
    import ffba_pkg::*;

    localparam logic [31:0] HDR     = 32'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

    ffba_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      top_reg, top_next;
    logic             op_reg, op_next;
    logic [30:0]      raw_reg, raw_next;
    logic [31:0]      key_reg, key_next;
    logic [33:0]      end_reg, end_next;
    logic [2:0]       status_reg, status_next;
    logic [31:0]      raddr_reg, raddr_next;

    logic             accept;
    logic             in_bad;
    logic             in_null;
    logic             cnt_zero;
    logic [CNT_W-1:0] cnt_m1;
    logic             hit;
    logic             no_room;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_bad   = in_item.request_size[31] || (in_item.request_size == 32'sd0);
    assign in_null  = (in_item.block_address == 32'd0);
    assign cnt_zero = (count_reg == '0);
    assign cnt_m1   = count_reg - 1'b1;

    // Free matches on the header address, which spares an adder in the walk.
    assign hit = (op_reg == OP_FREE) ? (ram_rd_data.base == key_reg)
                                     : (ram_rd_data.free && (ram_rd_data.size >= raw_reg));
    assign no_room = (count_reg >= CNT_MAX) || (end_reg > ({2'b00, cfg.limit} + 34'd1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_item.opcode == OP_ALLOC) begin
                        if (in_bad) begin
                            state_next = S_RESP;
                        end else if (cnt_zero) begin
                            state_next = S_APPEND;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else begin
                        if (in_null || cnt_zero) begin
                            state_next = S_RESP;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    state_next = S_RESP;
                end else if (idx_reg == '0) begin
                    state_next = (op_reg == OP_ALLOC) ? S_APPEND : S_RESP;
                end
            end
            S_APPEND: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        idx_next    = idx_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        op_next     = op_reg;
        raw_next    = raw_reg;
        key_next    = key_reg;
        end_next    = end_reg;
        status_next = status_reg;
        raddr_next  = raddr_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg - 1'b1;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = ram_rd_data;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next     = in_item.opcode;
                    raw_next    = in_item.request_size[30:0];
                    key_next    = in_item.block_address - HDR;
                    end_next    = {2'b00, top_reg} + {2'b00, HDR}
                                + {3'b000, in_item.request_size[30:0]};
                    raddr_next  = 32'd0;
                    status_next = STATUS_OK;
                    idx_next    = cnt_m1[IDX_W-1:0];
                    ram_rd_addr = cnt_m1[IDX_W-1:0];
                    if (in_item.opcode == OP_ALLOC) begin
                        if (in_bad) begin
                            status_next = STATUS_BAD_SIZE;
                        end else if (!cnt_zero) begin
                            ram_rd_en = 1'b1;
                        end
                    end else begin
                        if (in_null) begin
                            status_next = STATUS_NULL_FREE;
                        end else if (cnt_zero) begin
                            status_next = STATUS_UNKNOWN;
                        end else begin
                            ram_rd_en = 1'b1;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    ram_wr_en        = 1'b1;
                    ram_wr_data.free = (op_reg == OP_FREE);
                    status_next      = STATUS_OK;
                    raddr_next       = (op_reg == OP_ALLOC) ? (ram_rd_data.base + HDR) : 32'd0;
                end else if (idx_reg == '0) begin
                    if (op_reg == OP_FREE) begin
                        status_next = STATUS_UNKNOWN;
                    end
                end else begin
                    // advance to the next older entry
                    ram_rd_en = 1'b1;
                    idx_next  = idx_reg - 1'b1;
                end
            end
            S_APPEND: begin
                if (no_room) begin
                    status_next = STATUS_NO_MEMORY;
                    raddr_next  = 32'd0;
                end else begin
                    ram_wr_en        = 1'b1;
                    ram_wr_addr      = count_reg[IDX_W-1:0];
                    ram_wr_data.base = top_reg;
                    ram_wr_data.size = raw_reg;
                    ram_wr_data.free = 1'b0;
                    count_next       = count_reg + 1'b1;
                    top_next         = end_reg[31:0];
                    status_next      = STATUS_OK;
                    raddr_next       = top_reg + HDR;
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase

        // restart the heap
        if (cfg.base_wr) begin
            top_next   = cfg.base_val;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            top_reg   <= 32'd0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        raw_reg    <= raw_next;
        key_reg    <= key_next;
        end_reg    <= end_next;
        status_reg <= status_next;
        raddr_reg  <= raddr_next;
    end

    assign res.valid               = (state_reg == S_RESP);
    assign res.item.status         = status_reg;
    assign res.item.result_address = raddr_reg;

endmodule

FILE: hw/rtl/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit heap allocator over a table of up to MAX_BLOCKS blocks.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request word (allocate or free); m_* returns exactly one
//   result word per request. cfg_* writes heap_base (index 0) or heap_limit
//   (index 1); other indexes are ignored. Write configuration only when idle.
//   Writing heap_base restarts the heap and empties the block table.
// Timing:
//   The block table sits in one RAM with a registered read; a request walks it
//   newest first, one entry per cycle. A rejected or trivial request goes
//   straight to the result register, a walk ends on the first hit, and an
//   allocate that finds no free block large enough walks the whole table and
//   then appends a new block. One request is in flight at a time; the next
//   one is accepted in the cycle after the result register loads.
// Reset and stall:
//   Reset empties the table, sets heap_top to 0 and heap_limit to all ones.
//   The result register holds a word while m_ready is low; the next request
//   is still accepted and worked on, and waits for the register to drain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ffba_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ffba_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);
    import ffba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    logic [31:0] heap_limit_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    cfg_t             cfg;
    res_t             res;
    logic             res_ready;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    entry_t           ram_wr_data;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    entry_t           ram_rd_data;

    assign cfg_ready    = 1'b1;
    assign cfg.base_wr  = cfg_valid && (cfg_index == REG_HEAP_BASE);
    assign cfg.base_val = cfg_data;
    assign cfg.limit    = heap_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_limit_reg <= HEAP_LIMIT_RST;
        end else if (cfg_valid && (cfg_index == REG_HEAP_LIMIT)) begin
            heap_limit_reg <= cfg_data;
        end
    end

    ffba_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_item     (s_data),
        .cfg         (cfg),
        .res         (res),
        .res_ready   (res_ready),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    ffba_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Result register: load when empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res.valid) begin
            m_data_reg <= res.item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_CLK(a_one_in_flight, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "request accepted while another is in flight")
    `ASSERT_CLK(a_result_from_ctrl, aclk, aresetn, $rose(m_valid_reg) |-> $past(res.valid), "result word appeared without a finished request")
    `ASSERT_NEVER(a_fail_no_addr, aclk, aresetn, m_valid && (m_data.status != STATUS_OK) && (m_data.result_address != 32'd0), "failed request carries an address")

endmodule

FILE: tb/ffba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Watches the request, result and register channels of the first-fit block
// allocator, keeps its own copy of the block table and heap pointers, works
// out the answer to each accepted request word and compares every result
// word field by field against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module ffba_checker #(
    parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  ffba_pkg::in_item_t             s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  ffba_pkg::out_item_t            m_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    import ffba_pkg::*;

    logic [31:0] blk_base [MAX_BLOCKS];
    logic [30:0] blk_size [MAX_BLOCKS];
    logic        blk_free [MAX_BLOCKS];
    int          blk_count;
    logic [31:0] heap_top;
    logic [31:0] heap_limit_q;

    out_item_t   pending_results[$];

    function automatic out_item_t serve_request(input in_item_t req);
        out_item_t   res;
        logic [31:0] raw;
        logic [32:0] span_end;
        bit          hit;
        int          k;
        res.status         = STATUS_OK;
        res.result_address = '0;
        raw                = req.request_size;
        hit                = 1'b0;
        if (req.opcode == OP_ALLOC) begin
            if (raw == 32'd0 || raw[31]) begin
                res.status = STATUS_BAD_SIZE;
            end else begin
                // newest free block that is big enough wins
                for (k = blk_count - 1; k >= 0; k--) begin
                    if (!hit && blk_free[k] && blk_size[k] >= raw[30:0]) begin
                        blk_free[k]        = 1'b0;
                        res.result_address = blk_base[k] + 32'(HEADER_BYTES);
                        hit                = 1'b1;
                    end
                end
                if (!hit) begin
                    span_end = {1'b0, heap_top} + 33'(HEADER_BYTES) + {1'b0, raw};
                    if (blk_count >= MAX_BLOCKS || span_end > {1'b0, heap_limit_q} + 33'd1) begin
                        res.status = STATUS_NO_MEMORY;
                    end else begin
                        blk_base[blk_count] = heap_top;
                        blk_size[blk_count] = raw[30:0];
                        blk_free[blk_count] = 1'b0;
                        blk_count++;
                        res.result_address  = heap_top + 32'(HEADER_BYTES);
                        heap_top            = span_end[31:0];
                    end
                end
            end
        end else begin
            if (req.block_address == 32'd0) begin
                res.status = STATUS_NULL_FREE;
            end else begin
                for (k = blk_count - 1; k >= 0; k--) begin
                    if (!hit && blk_base[k] + 32'(HEADER_BYTES) == req.block_address) begin
                        blk_free[k] = 1'b1;
                        hit         = 1'b1;
                    end
                end
                if (!hit) begin
                    res.status = STATUS_UNKNOWN;
                end
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        out_item_t exp_word;
        if (!aresetn) begin
            blk_count    = 0;
            heap_top     = '0;
            heap_limit_q = HEAP_LIMIT_RST;
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_HEAP_BASE) begin
                    // restart the heap: table empties, top moves to the new base
                    heap_top  = cfg_data;
                    blk_count = 0;
                end else if (cfg_index == REG_HEAP_LIMIT) begin
                    heap_limit_q = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(serve_request(s_data));
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no request pending: status %0d address %h",
                           m_data.status, m_data.result_address);
                    fail_count++;
                end else begin
                    exp_word = pending_results.pop_front();
                    if (m_data.status !== exp_word.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_word.status, m_data.status);
                        fail_count++;
                    end
                    if (m_data.result_address !== exp_word.result_address) begin
                        $error("result_address mismatch: expected %h, actual %h",
                               exp_word.result_address, m_data.result_address);
                        fail_count++;
                    end
                end
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the first-fit block allocator with a short directed sequence and
// then randomized allocate/free traffic over several heap base and limit
// settings, with bursty requests and a stalling result side. Checking is
// done by ffba_checker; this module builds stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import ffba_pkg::*;

    localparam int MAX_BLOCKS   = DEF_MAX_BLOCKS;
    localparam int HEADER_BYTES = DEF_HEADER_BYTES;
    localparam int IDLE_LIMIT   = 5000;
    localparam int LONG_HOLD    = 900;
    localparam int N_PHASES     = 9;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'h7E;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    int                   fail_count;
    int                   outstanding;
    int                   words_sent  = 0;
    int                   burst_left  = 0;
    logic [31:0]          granted[$];

    // per phase: heap base, heap limit, whether base is rewritten, word count
    logic [31:0] phase_base  [N_PHASES] = '{32'h0000_1000, 32'h0, 32'h2000_0000,
                                            32'hFFFF_FFFF, 32'h0, 32'hFFFF_F000,
                                            32'h0, 32'h0000_0100, 32'h0};
    logic [31:0] phase_limit [N_PHASES] = '{32'hFFFF_FFFF, 32'h0000_1000, 32'h2000_0FFF,
                                            32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                            32'h0, 32'hFFFF_FFFF, 32'h8000_0000};
    bit          phase_rebase[N_PHASES] = '{1, 0, 1, 1, 1, 1, 1, 1, 0};
    int          phase_words [N_PHASES] = '{300, 150, 250, 60, 60, 250, 250, 300, 180};

    first_fit_block_allocator_core #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .HEADER_BYTES(HEADER_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    ffba_checker #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic in_item_t alloc_word(input logic [31:0] size);
        in_item_t w;
        w.opcode        = OP_ALLOC;
        w.request_size  = size;
        w.block_address = $urandom;
        return w;
    endfunction

    function automatic in_item_t free_word(input logic [31:0] addr);
        in_item_t w;
        w.opcode        = OP_FREE;
        w.request_size  = $urandom;
        w.block_address = addr;
        return w;
    endfunction

    task automatic send_word(input in_item_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        // old addresses die with the table
        if (idx == REG_HEAP_BASE) begin
            granted.delete();
        end
    endtask

    task automatic drain_results();
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // remember granted addresses so that frees mostly hit live blocks
    always @(posedge aclk) begin
        if (m_valid && m_ready && m_data.status == STATUS_OK && m_data.result_address != 0) begin
            granted.push_back(m_data.result_address);
            if (granted.size() > 96) begin
                void'(granted.pop_front());
            end
        end
    end

    // result side: stall in segments of random character, plus one long hold
    initial begin
        int  kind;
        int  seg_len;
        bit  held;
        held = 1'b0;
        forever begin
            if (!held && words_sent >= 400) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                kind    = $urandom_range(0, 9);
                seg_len = $urandom_range(20, 200);
                repeat (seg_len) begin
                    case (kind)
                        0, 1, 2, 3: m_ready <= 1'b1;
                        4, 5, 6:    m_ready <= 1'($urandom_range(0, 1));
                        7, 8:       m_ready <= ($urandom_range(0, 5) == 0);
                        default:    m_ready <= 1'b0;
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                    || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        in_item_t    directed[$];
        in_item_t    w;
        logic [31:0] sz;
        logic [31:0] addr;
        logic [31:0] base_v;
        logic [31:0] limit_v;
        int          k;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: base 0, limit all ones
        directed.push_back(alloc_word(32'h0000_0000));
        directed.push_back(alloc_word(32'h8000_0000));
        directed.push_back(alloc_word(32'hFFFF_FFFF));
        directed.push_back(free_word(32'h0000_0000));
        directed.push_back(free_word(32'hDEAD_BEEF));
        directed.push_back(alloc_word(32'h7FFF_FFF4));
        directed.push_back(alloc_word(32'd100));
        directed.push_back(alloc_word(32'h7FFF_FFFF));
        // ends exactly at the limit; heap top wraps to zero
        directed.push_back(alloc_word(32'h7FFF_FF84));
        // lands on the same usable address as the first block
        directed.push_back(alloc_word(32'd4));
        directed.push_back(free_word(32'd12));
        directed.push_back(free_word(32'd12));
        directed.push_back(alloc_word(32'd4));
        directed.push_back(free_word(32'h8000_000C));
        directed.push_back(alloc_word(32'd50));
        directed.push_back(free_word(32'h8000_000C));
        directed.push_back(free_word(32'd12));
        directed.push_back(alloc_word(32'd3));
        directed.push_back(alloc_word(32'd2));
        directed.push_back(alloc_word(32'h7FFF_FFE0));
        directed.push_back(free_word(32'd29));
        foreach (directed[i]) begin
            send_word(directed[i]);
        end
        s_valid <= 1'b0;
        drain_results();

        for (int p = 0; p < N_PHASES; p++) begin
            base_v  = phase_base[p];
            limit_v = phase_limit[p];
            if (p == 6) begin
                base_v  = $urandom;
                limit_v = $urandom;
                if (limit_v < base_v) begin
                    {base_v, limit_v} = {limit_v, base_v};
                end
            end
            if (p == N_PHASES - 1) begin
                write_reg(REG_SPARE, $urandom);
            end
            write_reg(REG_HEAP_LIMIT, limit_v);
            if (phase_rebase[p]) begin
                write_reg(REG_HEAP_BASE, base_v);
            end

            repeat (phase_words[p]) begin
                k = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 55) begin
                    if (k < 60)      sz = $urandom_range(1, 64);
                    else if (k < 80) sz = $urandom_range(1, 4096);
                    else if (k < 85) sz = '0;
                    else if (k < 90) sz = $urandom | 32'h8000_0000;
                    else if (k < 95) sz = $urandom;
                    else             sz = 32'h7FFF_FFFF - $urandom_range(0, 15);
                    w = alloc_word(sz);
                end else begin
                    if (k < 70 && granted.size() > 0) begin
                        addr = granted[$urandom_range(0, granted.size() - 1)];
                    end else if (k < 78) begin
                        addr = '0;
                    end else if (k < 88 && granted.size() > 0) begin
                        addr = granted[$urandom_range(0, granted.size() - 1)]
                               + $urandom_range(1, 3);
                    end else begin
                        addr = $urandom;
                    end
                    w = free_word(addr);
                end
                send_word(w);
            end
            s_valid <= 1'b0;
            drain_results();
        end

        repeat (MAX_BLOCKS + 8) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
